// ----- sv/dsct_pkg.sv -----
// Package for the degree sine/cosine table: shared types, the cosine table and
// the fixed-point constants for reduction modulo 360 and division by 5.
// No dependencies.
`default_nettype none

package dsct_pkg;

  // Sine is cosine of (90 - angle).
  localparam logic signed [16:0] QuarterTurn = 17'sd90;

  // Bias that makes every possible cosine argument non-negative (360 * 92).
  localparam logic [16:0] ModBias = 17'd33120;

  // floor(y / 360) ~= (y * ModRecip) >> ModShift, low by at most one.
  localparam logic [15:0] ModRecip = 16'd46603;
  localparam int          ModShift = 24;
  localparam logic [9:0]  FullTurn = 10'd360;

  // Fold boundaries in degrees.
  localparam logic [8:0] Deg90  = 9'd90;
  localparam logic [8:0] Deg180 = 9'd180;
  localparam logic [8:0] Deg270 = 9'd270;
  localparam logic [8:0] Deg360 = 9'd360;

  // floor(n / 5) == (n * Div5Recip) >> Div5Shift for every n below 1024.
  localparam logic [7:0] Div5Recip = 8'd205;
  localparam int         Div5Shift = 10;
  localparam logic [2:0] StepDeg   = 3'd5;

  // Index of the last table entry (90 degrees).
  localparam logic [4:0] LastIdx = 5'd18;

  // Folded angle, 0..90, and whether the cosine is negated.
  typedef struct packed {
    logic [6:0] fold;
    logic       neg;
  } fold_t;

  // Table entry, interpolation step magnitude before division by 5, sign.
  typedef struct packed {
    logic [9:0] base;
    logic [8:0] step_mag;
    logic       neg;
  } interp_t;

  // cos(5 * idx degrees) * 1000, rounded.
  function automatic logic [9:0] cos_entry(input logic [4:0] idx);
    logic [9:0] val;
    case (idx)
      5'd0:    val = 10'd1000;
      5'd1:    val = 10'd996;
      5'd2:    val = 10'd985;
      5'd3:    val = 10'd966;
      5'd4:    val = 10'd940;
      5'd5:    val = 10'd906;
      5'd6:    val = 10'd866;
      5'd7:    val = 10'd819;
      5'd8:    val = 10'd766;
      5'd9:    val = 10'd707;
      5'd10:   val = 10'd643;
      5'd11:   val = 10'd574;
      5'd12:   val = 10'd500;
      5'd13:   val = 10'd423;
      5'd14:   val = 10'd342;
      5'd15:   val = 10'd259;
      5'd16:   val = 10'd174;
      5'd17:   val = 10'd87;
      5'd18:   val = 10'd0;
      default: val = 10'd0;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

// ----- sv/dsct_in_if.sv -----
// Input channel of the degree sine/cosine table: valid/ready plus one angle word.
// No dependencies.
`default_nettype none

interface dsct_in_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic signed [15:0] angle_degrees;

  modport source (output valid, output command, output angle_degrees, input ready);
  modport sink   (input valid, input command, input angle_degrees, output ready);
endinterface

`default_nettype wire

// ----- sv/dsct_out_if.sv -----
// Output channel of the degree sine/cosine table: valid/ready plus one result word.
// No dependencies.
`default_nettype none

interface dsct_out_if;
  logic               valid;
  logic               ready;
  logic signed [10:0] trig_value;

  modport source (output valid, output trig_value, input ready);
  modport sink   (input valid, input trig_value, output ready);
endinterface

`default_nettype wire

// ----- sv/dsct_reduce.sv -----
// Finishes the reduction modulo 360 and folds the angle into 0..90 with a sign.
// Depends on dsct_pkg.
`default_nettype none

module dsct_reduce
  import dsct_pkg::*;
(
  input  logic [16:0] biased,
  input  logic [7:0]  quot,
  output fold_t       folded
);

  logic [16:0] turns;
  logic [16:0] diff;
  logic [9:0]  rough;
  logic [8:0]  deg;

  // The quotient estimate may be one short, so the remainder lies in 0..719.
  assign turns = 17'(quot) * 17'(FullTurn);
  assign diff  = biased - turns;
  assign rough = diff[9:0];
  assign deg   = (rough >= FullTurn) ? 9'(rough - FullTurn) : rough[8:0];

  always_comb begin
    if (deg <= Deg90) begin
      folded.fold = deg[6:0];
      folded.neg  = 1'b0;
    end else if (deg <= Deg180) begin
      folded.fold = 7'(Deg180 - deg);
      folded.neg  = 1'b1;
    end else if (deg <= Deg270) begin
      folded.fold = 7'(deg - Deg180);
      folded.neg  = 1'b1;
    end else begin
      folded.fold = 7'(Deg360 - deg);
      folded.neg  = 1'b0;
    end
  end

endmodule

`default_nettype wire

// ----- sv/dsct_interp.sv -----
// Splits the folded angle into table index and remainder, reads the two table
// entries and forms the interpolation step magnitude. Depends on dsct_pkg.
`default_nettype none

module dsct_interp
  import dsct_pkg::*;
(
  input  fold_t   folded,
  output interp_t interp
);

  logic [14:0] scaled;
  logic [4:0]  idx;
  logic [6:0]  five_idx;
  logic [2:0]  rem;
  logic [9:0]  base;
  logic [9:0]  nxt;
  logic [6:0]  delta;
  logic [9:0]  step_full;

  assign scaled   = 15'(folded.fold) * 15'(Div5Recip);
  assign idx      = scaled[14:Div5Shift];
  assign five_idx = 7'(idx) * 7'(StepDeg);
  assign rem      = 3'(folded.fold - five_idx);

  // The table falls monotonically, so the step toward the next entry is
  // never positive; carry its magnitude.
  assign base      = cos_entry(idx);
  assign nxt       = (idx < LastIdx) ? cos_entry(idx + 5'd1) : base;
  assign delta     = 7'(base - nxt);
  assign step_full = 10'(delta) * 10'(rem);

  assign interp.base     = base;
  assign interp.step_mag = step_full[8:0];
  assign interp.neg      = folded.neg;

endmodule

`default_nettype wire

// ----- sv/degree_sine_cosine_table.sv -----
// Top level of the degree sine/cosine table: a five-stage pipeline that turns
// an angle word into cos or sin times 1000. Depends on dsct_pkg, dsct_in_if,
// dsct_out_if, dsct_reduce and dsct_interp.
`default_nettype none

// Channel  Dir  Fields                                     Handshake
// -------  ---  -----------------------------------------  ------------
// angle    in   command (1, 0 cos / 1 sin), angle_degrees  valid/ready
//                (16 signed)
// trig     out  trig_value (11 signed, -1000..1000)        valid/ready
//
// One word is accepted every cycle unless a stalled output has filled every stage;
// each word passes through the five pipeline registers in order (input,
// loaded on the accepting edge, then modulo estimate, fold, table step, result).
// rst is synchronous and clears only the stage valid bits; data needs no reset.
// Each stage loads whenever it is empty or the stage after it moves, so a
// stalled output only holds back words that have nowhere to go, and bubbles
// in the pipeline are squeezed out while the result waits.

module degree_sine_cosine_table
  import dsct_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  dsct_in_if.sink    angle,
  dsct_out_if.source trig
);

  // Stage valid bits and per-stage advance enables.
  logic [4:0] vld;
  logic [4:0] adv;

  // Stage 0: the accepted word.
  logic               cmd;
  logic signed [15:0] ang;

  // Stage 1: biased cosine argument and quotient estimate.
  logic [16:0] biased;
  logic [7:0]  quot;

  // Stage 2: folded angle. Stage 3: table entry and step.
  fold_t   folded;
  interp_t interp;

  // Stage 4: result register.
  logic signed [10:0] result;

  // Combinational values between the stages.
  logic signed [16:0] ang_ext;
  logic signed [16:0] cos_arg;
  logic [16:0]        biased_next;
  logic [32:0]        prod;
  fold_t              folded_next;
  interp_t            interp_next;
  logic [16:0]        div5_full;
  logic [6:0]         step_div5;
  logic [9:0]         mag;
  logic [10:0]        mag_ext;
  logic signed [10:0] result_next;

  // A stage may load when it is empty or its contents move on this edge.
  always_comb begin
    adv[4] = !vld[4] || trig.ready;
    adv[3] = !vld[3] || adv[4];
    adv[2] = !vld[2] || adv[3];
    adv[1] = !vld[1] || adv[2];
    adv[0] = !vld[0] || adv[1];
  end

  assign angle.ready = adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) vld[0] <= angle.valid;
      if (adv[1]) vld[1] <= vld[0];
      if (adv[2]) vld[2] <= vld[1];
      if (adv[3]) vld[3] <= vld[2];
      if (adv[4]) vld[4] <= vld[3];
    end
  end

  // Sine becomes cosine of (90 - angle), formed at 17 bits so it never wraps.
  // Adding 360 * 92 makes the argument non-negative without changing it
  // modulo 360; the quotient by 360 then comes from a reciprocal multiply.
  assign ang_ext     = {ang[15], ang};
  assign cos_arg     = cmd ? (QuarterTurn - ang_ext) : ang_ext;
  assign biased_next = 17'(cos_arg) + ModBias;
  assign prod        = 33'(biased_next) * 33'(ModRecip);

  dsct_reduce u_reduce (
    .biased (biased),
    .quot   (quot),
    .folded (folded_next)
  );

  dsct_interp u_interp (
    .folded (folded),
    .interp (interp_next)
  );

  // The step is never positive, so truncation toward zero of step / 5 is the
  // floor of its magnitude over 5, taken off the table entry.
  assign div5_full   = 17'(interp.step_mag) * 17'(Div5Recip);
  assign step_div5   = div5_full[16:Div5Shift];
  assign mag         = interp.base - 10'(step_div5);
  assign mag_ext     = {1'b0, mag};
  assign result_next = interp.neg ? $signed(~mag_ext + 11'd1) : $signed(mag_ext);

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      cmd <= angle.command;
      ang <= angle.angle_degrees;
    end
    if (adv[1]) begin
      biased <= biased_next;
      quot   <= prod[31:ModShift];
    end
    if (adv[2]) folded <= folded_next;
    if (adv[3]) interp <= interp_next;
    if (adv[4]) result <= result_next;
  end

  assign trig.valid      = vld[4];
  assign trig.trig_value = result;

  // An empty output stage means every stage can move, so input is open.
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !vld[4] |-> angle.ready)
    else $error("input not ready while output stage is empty");

  // The fold always lands in the first quadrant.
  a_fold_range: assert property (@(posedge clk) disable iff (rst)
    vld[2] |-> (folded.fold <= 7'd90))
    else $error("folded angle above 90 degrees");

  a_result_range: assert property (@(posedge clk) disable iff (rst)
    vld[4] |-> ($signed(result) <= 11'sd1000 && $signed(result) >= -11'sd1000))
    else $error("result outside -1000..1000");

  // A taken result with nothing behind it leaves the output empty.
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (vld[4] && trig.ready && !vld[3]) |=> !vld[4])
    else $error("result repeated after it was taken");

endmodule

`default_nettype wire
